// File: sv/tias_pkg.sv
// Shared types and constants for the track isolation annulus sum block.
// Used by the front, the back and the top level; depends on nothing.
package tias_pkg;

  // Field widths
  localparam int ETA_W    = 13;
  localparam int PHI_W    = 12;
  localparam int Z_W      = 16;
  localparam int PT_W     = 16;
  localparam int RAD_W    = 12;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PT_SUM_W = 24;

  // Accumulator width default and queue depths
  localparam int SUM_WIDTH_DEF = 24;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 4;

  // Opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PT_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z_DIST   = 2'd3;

  // Configuration reset values
  localparam logic [RAD_W-1:0] OUTER_RADIUS_RST = 12'd196;
  localparam logic [RAD_W-1:0] INNER_RADIUS_RST = 12'd10;
  localparam logic [PT_W-1:0]  PT_THRESHOLD_RST = 16'd64;
  localparam logic [Z_W-1:0]   MAX_Z_DIST_RST   = 16'd20;

  // Live configuration
  typedef struct packed {
    logic [RAD_W-1:0] outer_radius;
    logic [RAD_W-1:0] inner_radius;
    logic [PT_W-1:0]  pt_threshold;
    logic [Z_W-1:0]   max_z_distance;
  } cfg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic             op;
    logic             qual;     // passed pt and z cuts
    logic [ETA_W-1:0] abs_deta;
    logic [PHI_W-1:0] abs_dphi; // shorter way round, at most 2048
    logic [PT_W-1:0]  pt;
    logic             last;
  } mid_item_t;

  // Result item
  typedef struct packed {
    logic [PT_SUM_W-1:0] pt_sum;
    logic                saturated;
  } out_item_t;

endpackage

// File: sv/tias_queue.sv
// Small first-in first-out queue with registered storage.
// Generic; used between front and back and on the result side.
module tias_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/tias_front.sv
// Front part: holds the reference track, applies pt and z cuts and forms
// the eta and phi distances. Depends on tias_pkg.
module tias_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     opcode,
  input  logic signed [tias_pkg::ETA_W-1:0] eta,
  input  logic [tias_pkg::PHI_W-1:0] phi,
  input  logic signed [tias_pkg::Z_W-1:0]   z0,
  input  logic [tias_pkg::PT_W-1:0]  pt,
  input  logic                     last,
  input  tias_pkg::cfg_t           cfg,
  output tias_pkg::mid_item_t      item
);
  import tias_pkg::*;

  logic signed [ETA_W-1:0] ref_eta_r;
  logic [PHI_W-1:0]        ref_phi_r;
  logic signed [Z_W-1:0]   ref_z_r;

  logic signed [Z_W:0]     dz;
  logic [Z_W:0]            abs_dz;
  logic signed [ETA_W:0]   deta;
  logic [ETA_W:0]          abs_deta;
  logic [PHI_W-1:0]        dphi;

  // Reference track, loaded by opcode 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_eta_r <= '0;
      ref_phi_r <= '0;
      ref_z_r   <= '0;
    end else if (accept && opcode == OP_LOAD) begin
      ref_eta_r <= eta;
      ref_phi_r <= phi;
      ref_z_r   <= z0;
    end
  end

  // Distances to the reference
  always_comb begin
    dz       = (Z_W+1)'(z0) - (Z_W+1)'(ref_z_r);
    abs_dz   = dz[Z_W] ? (Z_W+1)'(-dz) : (Z_W+1)'(dz);
    deta     = (ETA_W+1)'(eta) - (ETA_W+1)'(ref_eta_r);
    abs_deta = deta[ETA_W] ? (ETA_W+1)'(-deta) : (ETA_W+1)'(deta);
    dphi     = phi - ref_phi_r;
    // wrap to the shorter way round the circle
    if (dphi > 12'd2048) begin
      dphi = ~dphi + 1'b1;
    end
  end

  // Classified item
  always_comb begin
    item.op       = opcode;
    item.qual     = (pt >= cfg.pt_threshold) && (abs_dz <= {1'b0, cfg.max_z_distance});
    item.abs_deta = abs_deta[ETA_W-1:0];
    item.abs_dphi = dphi;
    item.pt       = pt;
    item.last     = last;
  end

endmodule

// File: sv/tias_back.sv
// Back part: squares the distances, tests the annulus and accumulates the
// saturating pt sum; emits one result per last track. Depends on tias_pkg.
module tias_back #(
  parameter int SUM_WIDTH = tias_pkg::SUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tias_pkg::cfg_t       cfg,
  input  tias_pkg::mid_item_t  mid_item,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output tias_pkg::out_item_t  res_item
);
  import tias_pkg::*;

  localparam int SQ_E_W = 2 * ETA_W;
  localparam int SQ_P_W = 2 * PHI_W;
  localparam int D2_W   = SQ_E_W + 1;
  localparam int R2_W   = 2 * RAD_W;

  logic                 adv;

  // radius squares, refreshed every cycle from the configuration
  logic [R2_W-1:0]      outer_r2_r, inner_r2_r;

  // stage 1: squares
  logic                 s1_v_r, s1_op_r, s1_qual_r, s1_last_r;
  logic [PT_W-1:0]      s1_pt_r;
  logic [SQ_E_W-1:0]    s1_esq_r;
  logic [SQ_P_W-1:0]    s1_psq_r;

  // stage 2: annulus decision
  logic                 s2_v_r, s2_op_r, s2_add_r, s2_last_r;
  logic [PT_W-1:0]      s2_pt_r;
  logic [D2_W-1:0]      d2;
  logic                 hit;

  // accumulator
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [SUM_WIDTH:0]   acc_w;

  assign adv     = !res_full;
  assign mid_pop = adv && !mid_empty;

  always_ff @(posedge clk) begin
    outer_r2_r <= R2_W'(cfg.outer_radius) * R2_W'(cfg.outer_radius);
    inner_r2_r <= R2_W'(cfg.inner_radius) * R2_W'(cfg.inner_radius);
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= !mid_empty;
      s2_v_r <= s1_v_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= mid_item.op;
      s1_qual_r <= mid_item.qual;
      s1_last_r <= mid_item.last;
      s1_pt_r   <= mid_item.pt;
      s1_esq_r  <= SQ_E_W'(mid_item.abs_deta) * SQ_E_W'(mid_item.abs_deta);
      s1_psq_r  <= SQ_P_W'(mid_item.abs_dphi) * SQ_P_W'(mid_item.abs_dphi);
    end
  end

  // Stage 2: inner^2 <= d2 < outer^2
  always_comb begin
    d2  = D2_W'(s1_esq_r) + D2_W'(s1_psq_r);
    hit = s1_qual_r && (d2 >= D2_W'(inner_r2_r)) && (d2 < D2_W'(outer_r2_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r   <= s1_op_r;
      s2_add_r  <= hit;
      s2_last_r <= s1_last_r;
      s2_pt_r   <= s1_pt_r;
    end
  end

  // Saturating accumulate; a load item clears the sum and the overflow flag
  always_comb begin
    acc_w   = {1'b0, sum_r} + (SUM_WIDTH+1)'(s2_pt_r);
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    if (s2_op_r == OP_LOAD) begin
      sum_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (s2_add_r) begin
      if (acc_w[SUM_WIDTH]) begin
        sum_nxt = '1;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = acc_w[SUM_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else if (adv && s2_v_r) begin
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Result on a last track
  assign res_push           = adv && s2_v_r && (s2_op_r == OP_TRACK) && s2_last_r;
  assign res_item.pt_sum    = PT_SUM_W'(sum_nxt);
  assign res_item.saturated = ovf_nxt;

endmodule

// File: sv/track_isolation_annulus_sum_core.sv
// Track isolation annulus sum: top level with configuration registers,
// front, back and the two queues. Depends on tias_pkg, tias_front,
// tias_back and tias_queue.
//
// Input channel: an item is taken when in_push is high and in_full is low.
// Opcode 0 loads the reference track and clears the sum; opcode 1 presents
// a track, and a track with in_last set produces one result.
// Result channel: while out_empty is low the oldest result sits on
// out_pt_sum/out_saturated; out_pop takes it.
// Configuration: cfg_valid with cfg_index/cfg_data writes a register;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one item per cycle while in_full is low. An accepted last track
// passes the middle queue slot, the squaring stage and the annulus compare
// stage; the sum is formed as the result enters the queue.
// When the receiver stalls, the result queue fills, the back pipeline
// holds, then the middle queue fills and in_full rises.
// Reset (synchronous, rst_n low) clears the queues, the reference track,
// the sum and the overflow flag and loads the register reset values.
module track_isolation_annulus_sum_core #(
  parameter int SUM_WIDTH = tias_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_opcode,
  input  logic signed [tias_pkg::ETA_W-1:0]     in_eta,
  input  logic [tias_pkg::PHI_W-1:0]            in_phi,
  input  logic signed [tias_pkg::Z_W-1:0]       in_z0,
  input  logic [tias_pkg::PT_W-1:0]             in_pt,
  input  logic                                  in_last,
  // result channel
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [tias_pkg::PT_SUM_W-1:0]         out_pt_sum,
  output logic                                  out_saturated,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tias_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tias_pkg::CFG_W-1:0]            cfg_data
);
  import tias_pkg::*;

  localparam int MID_W = $bits(mid_item_t);
  localparam int OUT_W = $bits(out_item_t);

  cfg_t       cfg_r;
  mid_item_t  mid_wr, mid_rd;
  out_item_t  res_item, out_item;
  logic       mid_full, mid_empty, mid_pop;
  logic       res_push, res_full;
  logic       in_accept;

  assign cfg_ready = 1'b1;
  assign in_full   = mid_full;
  assign in_accept = in_push && !mid_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_radius   <= OUTER_RADIUS_RST;
      cfg_r.inner_radius   <= INNER_RADIUS_RST;
      cfg_r.pt_threshold   <= PT_THRESHOLD_RST;
      cfg_r.max_z_distance <= MAX_Z_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OUTER_RADIUS: cfg_r.outer_radius   <= cfg_data[RAD_W-1:0];
        CFG_INNER_RADIUS: cfg_r.inner_radius   <= cfg_data[RAD_W-1:0];
        CFG_PT_THRESHOLD: cfg_r.pt_threshold   <= cfg_data;
        CFG_MAX_Z_DIST:   cfg_r.max_z_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: reference and cuts
  tias_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .opcode (in_opcode),
    .eta    (in_eta),
    .phi    (in_phi),
    .z0     (in_z0),
    .pt     (in_pt),
    .last   (in_last),
    .cfg    (cfg_r),
    .item   (mid_wr)
  );

  // Queue between front and back
  tias_queue #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  // Back: squares, annulus test, accumulate
  tias_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_item  (mid_rd),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // Result queue
  tias_queue #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

  assign out_pt_sum    = out_item.pt_sum;
  assign out_saturated = out_item.saturated;

  // Checks
  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_sat_means_max: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_item.saturated |->
      res_item.pt_sum == PT_SUM_W'({SUM_WIDTH{1'b1}}))
    else $error("saturated result without maximum sum");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty && !res_full)
    else $error("middle queue popped while back stalled or queue empty");

endmodule
